/* hdl/hll_pkg.sv */
// Package for the HyperLogLog sketch: operation codes, field widths, states, queue entry.
// No dependencies.
package hll_pkg;

  localparam int BucketBitsDefault = 10;
  localparam int SumW  = 43;
  localparam int ZeroW = 11;
  localparam int EstW  = 40;
  localparam int HashW = 32;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV,
    ST_OUT
  } state_t;

  // Queue entry from front to back.
  typedef struct packed {
    op_t        op;
    logic [HashW-1:0] hash;
  } item_t;

endpackage

/* hdl/hll_front.sv */
// Front end: accepts items, drops unused codes, and queues them in a short FIFO.
// Depends on hll_pkg.
module hll_front import hll_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             valid,
  output logic             ready,
  input  logic [1:0]       operation,
  input  logic [HashW-1:0] hash_value,
  output logic             q_valid,
  input  logic             q_ready,
  output item_t            q_item
);

  localparam int Depth = 4;

  item_t      mem [Depth];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       push;
  logic       pop;

  assign ready   = (count != 3'(Depth));
  assign push    = valid && ready && (operation != OP_NONE);
  assign q_valid = (count != 3'd0);
  assign pop     = q_valid && q_ready;
  assign q_item  = mem[rd_ptr];

  // Store classified items.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{op: op_t'(operation), hash: hash_value};
    end
  end

  // Advance pointers and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

endmodule

/* hdl/hll_back.sv */
// Back end: bucket memory, add read-modify-write, clear sweep, query scan and divide.
// Depends on hll_pkg.
module hll_back import hll_pkg::*; #(
  parameter int BUCKET_BITS = BucketBitsDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_ready,
  input  item_t            q_item,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [SumW-1:0]  harmonic_sum,
  output logic [ZeroW-1:0] zero_buckets,
  output logic [EstW-1:0]  raw_estimate
);

  localparam int M     = 1 << BUCKET_BITS;
  localparam int LowW  = HashW - BUCKET_BITS;
  localparam int AccW  = 64;
  // Alpha in 16-fraction-bit fixed point, general formula rounded with ties up.
  localparam longint unsigned AlphaDen = 64'd10 * (64'd1000 * 64'(M) + 64'd1079);
  localparam longint unsigned AlphaGen =
    (64'd7213 * 64'(M) * 64'd65536 + AlphaDen / 64'd2) / AlphaDen;
  localparam longint unsigned AlphaFx = (M == 16) ? 64'd44106 :
                                        (M == 32) ? 64'd45679 :
                                        (M == 64) ? 64'd46465 : AlphaGen;
  localparam longint unsigned Numer = AlphaFx * 64'(M) * 64'(M) * 64'd65536;
  localparam int QW    = 64;
  localparam int DivCW = 7;

  logic [4:0] mem [M];

  state_t state;
  state_t state_next;

  // Add pipeline: stage 1 reads, stage 2 writes the larger rank.
  logic                   a_vld;
  logic [BUCKET_BITS-1:0] a_idx;
  logic [4:0]             a_rank;
  logic [4:0]             rd_data;
  logic                   w_vld;
  logic [BUCKET_BITS-1:0] w_idx;
  logic [4:0]             w_rank;

  logic [BUCKET_BITS:0]   ptr;
  logic [AccW-1:0]        sum;
  logic [BUCKET_BITS:0]   zeros;
  logic                   s_vld;
  logic [AccW-1:0]        rem;
  logic [QW-1:0]          quo;
  logic [DivCW-1:0]       dcnt;
  logic [LowW-1:0]        low;
  logic [4:0]             new_rank;
  logic                   take_add;
  logic                   rd_en;
  logic [BUCKET_BITS-1:0] rd_addr;
  logic [AccW:0]          trial;
  logic                   busy;

  // Rank: one plus leading zeros of the low bits.
  always_comb begin
    low      = q_item.hash[LowW-1:0];
    new_rank = 5'(LowW + 1);
    for (int b = 0; b < LowW; b++) begin
      if (low[b]) new_rank = 5'(LowW - b);
    end
  end

  assign take_add = (state == ST_IDLE) && q_valid && (q_item.op == OP_ADD);
  assign q_ready  = (state == ST_IDLE) && q_valid && ((q_item.op == OP_ADD) || !busy);
  assign rd_en    = take_add || (state == ST_SCAN);
  assign rd_addr  = (state == ST_SCAN) ? ptr[BUCKET_BITS-1:0]
                                       : q_item.hash[HashW-1 -: BUCKET_BITS];
  assign busy     = a_vld || w_vld;

  // Bucket memory; forward a write landing on the same edge into the read.
  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= (w_vld && (w_idx == rd_addr)) ? w_rank : mem[rd_addr];
    if (state == ST_CLEAR) begin
      mem[ptr[BUCKET_BITS-1:0]] <= 5'd0;
    end else if (w_vld) begin
      mem[w_idx] <= w_rank;
    end
  end

  // Compare and write back; merge with a write to the same bucket in flight.
  logic [4:0] cur;
  always_comb begin
    cur = rd_data;
    if (w_vld && (w_idx == a_idx) && (w_rank > cur)) cur = w_rank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      w_vld <= 1'b0;
    end else begin
      a_vld <= take_add;
      w_vld <= a_vld && (a_rank > cur);
    end
    a_idx  <= q_item.hash[HashW-1 -: BUCKET_BITS];
    a_rank <= new_rank;
    w_idx  <= a_idx;
    w_rank <= a_rank;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid && !busy && q_item.op == OP_CLEAR) state_next = ST_CLEAR;
        else if (q_valid && !busy && q_item.op == OP_QUERY) state_next = ST_SCAN;
      end
      ST_CLEAR: if (ptr == (BUCKET_BITS+1)'(M - 1)) state_next = ST_IDLE;
      ST_SCAN:  if (ptr == (BUCKET_BITS+1)'(M - 1)) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_DIV;
      ST_DIV:   if (dcnt == DivCW'(QW - 1)) state_next = ST_OUT;
      ST_OUT:   if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  assign trial = {rem[AccW-1:0], Numer[QW-1-32'(dcnt)]} - {1'b0, sum};

  // Hold a query or clear until the add pipeline drains.
  logic q_wait;
  assign q_wait = busy && q_valid && (q_item.op != OP_ADD);

  // Reset starts a clear pass over every bucket.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      ptr   <= '0;
      s_vld <= 1'b0;
    end else begin
      if (!(state == ST_IDLE && q_wait)) state <= state_next;
      s_vld <= (state == ST_SCAN);
      if (state == ST_CLEAR || state == ST_SCAN) ptr <= ptr + 1'b1;
      else ptr <= '0;
    end
  end

  // Accumulate terms, then restoring division one quotient bit a cycle.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      sum   <= '0;
      zeros <= '0;
      dcnt  <= '0;
      rem   <= '0;
      quo   <= '0;
    end else begin
      if (s_vld) begin
        sum <= sum + (AccW'(1) << (32 - int'(rd_data)));
        if (rd_data == 5'd0) zeros <= zeros + 1'b1;
      end
      if (state == ST_DIV) begin
        dcnt <= dcnt + 1'b1;
        if (!trial[AccW]) begin
          rem <= trial[AccW-1:0];
          quo <= {quo[QW-2:0], 1'b1};
        end else begin
          rem <= {rem[AccW-2:0], Numer[QW-1-32'(dcnt)]};
          quo <= {quo[QW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid    = (state == ST_OUT);
  assign harmonic_sum = sum[SumW-1:0];
  assign zero_buckets = ZeroW'(zeros);
  assign raw_estimate = (quo[QW-1:EstW] != '0) ? {EstW{1'b1}} : quo[EstW-1:0];

endmodule

/* hdl/cardinality_sketch_estimator.sv */
// Top level of the HyperLogLog sketch: front queue and back execution unit.
// Depends on hll_pkg, hll_front, hll_back.
//
//  channel | direction | handshake   | payload
//  in      | input     | valid/ready | operation, hash_value
//  out     | output    | out_valid/out_ready | harmonic_sum, zero_buckets, raw_estimate
//
// Add: one per cycle while idle, in a two-stage read-modify-write on the bucket memory.
// Query: a scan of the bucket memory, then a restoring divider that forms the estimate.
// Clear: a sweep over every bucket, one bucket per cycle.
// Reset starts the same clear pass; the queue fills and input stalls until it ends.
// A four-entry queue lets input keep flowing while the back end stalls.
module cardinality_sketch_estimator import hll_pkg::*; #(
  parameter int BUCKET_BITS = BucketBitsDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             valid,
  output logic             ready,
  input  logic [1:0]       operation,
  input  logic [HashW-1:0] hash_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [SumW-1:0]  harmonic_sum,
  output logic [ZeroW-1:0] zero_buckets,
  output logic [EstW-1:0]  raw_estimate
);

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  hll_front u_front (
    .clk, .rst, .valid, .ready, .operation, .hash_value,
    .q_valid, .q_ready, .q_item
  );

  hll_back #(.BUCKET_BITS(BUCKET_BITS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item,
    .out_valid, .out_ready, .harmonic_sum, .zero_buckets, .raw_estimate
  );

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(raw_estimate)) else $error("out dropped");
  a_zero_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> zero_buckets <= ZeroW'(1 << BUCKET_BITS) || BUCKET_BITS > 10)
    else $error("zero count");
  a_qflow: assert property (@(posedge clk) disable iff (rst)
    q_ready |-> q_valid) else $error("pop empty");

endmodule
